/* rtl/tse_pkg.sv */
package tse_pkg;

    // Field widths of the packed store and the raster
    localparam int unsigned ADDR_BITS   = 22;
    localparam int unsigned COL_BITS    = 16;
    localparam int unsigned ROW_BITS    = 22;
    localparam int unsigned ACC_BITS    = 24;
    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [COL_BITS-1:0] MAX_ROW_WIDTH = 16'd4096;
    localparam logic [7:0]          PAD_BYTE      = 8'hCD;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ROW    = 2'd2
    } tse_kind_t;

    // One result beat
    typedef struct packed {
        tse_kind_t            kind;
        logic [ADDR_BITS-1:0] word_address;
        logic [31:0]          word;
    } tse_result_t;

    // All results caused by one pixel, in delivery order
    typedef struct packed {
        tse_result_t [MAX_RESULTS-1:0] res;
        logic [1:0]                    count;
        logic                          overflow;
    } tse_bundle_t;

    // Encoder state carried from pixel to pixel
    typedef struct packed {
        logic [COL_BITS-1:0]  column;
        logic [ROW_BITS-1:0]  row_count;
        logic                 span_open;
        logic [COL_BITS-1:0]  span_start_x;
        logic [15:0]          span_length;
        logic [ADDR_BITS-1:0] span_header_address;
        logic [ACC_BITS-1:0]  byte_accumulator;
        logic [1:0]           bytes_in_word;
        logic [ADDR_BITS-1:0] next_word_address;
        logic                 overflow_flag;
    } tse_state_t;

endpackage

/* rtl/tse_step.sv */
module tse_step (
    input  tse_pkg::tse_state_t  state,
    input  logic [7:0]           transparent_value,
    input  logic [7:0]           pixel,
    input  logic                 row_last,
    input  logic                 image_start,
    output tse_pkg::tse_state_t  state_next,
    output tse_pkg::tse_bundle_t bundle,
    output logic                 has_result
);
    import tse_pkg::*;

    tse_state_t  s;
    tse_bundle_t b;
    logic [1:0]  n;
    logic        opaque;
    logic [31:0] pad_word;

    // Reserve the next store word: return {wrapped, address + 1}
    function automatic logic [ADDR_BITS:0] bump(input logic [ADDR_BITS-1:0] a);
        logic [ADDR_BITS-1:0] nx;
        nx = a + 1'b1;
        return {(nx == '0), nx};
    endfunction

    always_comb
    begin
        s        = state;
        b        = '0;
        n        = 2'd0;
        pad_word = '0;

        // Restart the image: drop any open span
        if (image_start)
        begin
            s.column            = '0;
            s.row_count         = '0;
            s.span_open         = 1'b0;
            s.span_length       = '0;
            s.byte_accumulator  = '0;
            s.bytes_in_word     = '0;
            s.next_word_address = '0;
            s.overflow_flag     = 1'b0;
        end

        // Classify the pixel; past the row limit it is skipped
        opaque = (pixel != transparent_value);
        if (s.column >= MAX_ROW_WIDTH)
        begin
            s.overflow_flag = 1'b1;
            opaque          = 1'b0;
        end

        // Append an opaque pixel, opening a span if needed
        if (opaque)
        begin
            if (!s.span_open)
            begin
                s.span_open           = 1'b1;
                s.span_start_x        = s.column;
                s.span_length         = '0;
                s.span_header_address = s.next_word_address;
                {s.overflow_flag, s.next_word_address} =
                    bump(s.next_word_address) | {s.overflow_flag, {ADDR_BITS{1'b0}}};
                s.byte_accumulator    = '0;
                s.bytes_in_word       = '0;
            end
            if (s.bytes_in_word == 2'd3)
            begin
                b.res[n].kind         = KIND_DATA;
                b.res[n].word_address = s.next_word_address;
                b.res[n].word         = {pixel, s.byte_accumulator};
                n                     = n + 2'd1;
                {s.overflow_flag, s.next_word_address} =
                    bump(s.next_word_address) | {s.overflow_flag, {ADDR_BITS{1'b0}}};
                s.byte_accumulator    = '0;
                s.bytes_in_word       = '0;
            end
            else
            begin
                case (s.bytes_in_word)
                    2'd0:    s.byte_accumulator[7:0]   = pixel;
                    2'd1:    s.byte_accumulator[15:8]  = pixel;
                    2'd2:    s.byte_accumulator[23:16] = pixel;
                    default: s.byte_accumulator        = s.byte_accumulator;
                endcase
                s.bytes_in_word = s.bytes_in_word + 2'd1;
            end
            s.span_length = s.span_length + 16'd1;
        end

        // Close the span on a transparent pixel or at row end
        if (s.span_open && (!opaque || row_last))
        begin
            if (s.bytes_in_word != 2'd0)
            begin
                pad_word[7:0]   = s.byte_accumulator[7:0];
                pad_word[15:8]  = (s.bytes_in_word >= 2'd2) ?
                                  s.byte_accumulator[15:8] : PAD_BYTE;
                pad_word[23:16] = (s.bytes_in_word == 2'd3) ?
                                  s.byte_accumulator[23:16] : PAD_BYTE;
                pad_word[31:24] = PAD_BYTE;
                b.res[n].kind         = KIND_DATA;
                b.res[n].word_address = s.next_word_address;
                b.res[n].word         = pad_word;
                n                     = n + 2'd1;
                {s.overflow_flag, s.next_word_address} =
                    bump(s.next_word_address) | {s.overflow_flag, {ADDR_BITS{1'b0}}};
            end
            b.res[n].kind         = KIND_HEADER;
            b.res[n].word_address = s.span_header_address;
            b.res[n].word         = {s.span_length, s.span_start_x};
            n                     = n + 2'd1;
            s.span_open           = 1'b0;
            s.byte_accumulator    = '0;
            s.bytes_in_word       = '0;
        end

        // Emit the row-table record, or advance the column
        if (row_last)
        begin
            s.row_count = s.row_count + 1'b1;
            if (s.row_count == '0)
            begin
                s.overflow_flag = 1'b1;
            end
            b.res[n].kind         = KIND_ROW;
            b.res[n].word_address = s.row_count;
            b.res[n].word         = {8'd0, s.next_word_address, 2'b00};
            n                     = n + 2'd1;
            s.column              = '0;
        end
        else if (s.column < MAX_ROW_WIDTH)
        begin
            s.column = s.column + 16'd1;
        end

        b.count    = n;
        b.overflow = s.overflow_flag;
    end

    assign state_next = s;
    assign bundle     = b;
    assign has_result = (n != 2'd0);

endmodule

/* rtl/tse_queue.sv */
module tse_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tse_pkg::tse_bundle_t push_bundle,
    output logic                 full,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [1:0]           kind,
    output logic [21:0]          word_address,
    output logic [31:0]          word,
    output logic                 last,
    output logic                 overflow
);
    import tse_pkg::*;

    tse_bundle_t slot_reg [2];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  sub_reg;
    logic [1:0]  sub_next;
    logic        rd_ptr_next;
    tse_bundle_t head;
    tse_result_t cur;
    logic        pop;
    logic        head_done;

    assign head         = slot_reg[rd_ptr_reg];
    assign cur          = head.res[sub_reg];
    assign result_valid = (count_reg != 2'd0);
    assign full         = (count_reg == 2'd2);
    assign last         = (sub_reg == head.count - 2'd1);
    assign pop          = result_valid && !result_stall;
    assign head_done    = pop && last;

    assign kind         = cur.kind;
    assign word_address = cur.word_address;
    assign word         = cur.word;
    assign overflow     = head.overflow;

    // Step through the head group one beat at a time
    always_comb
    begin
        sub_next    = sub_reg;
        rd_ptr_next = rd_ptr_reg;
        if (head_done)
        begin
            sub_next    = 2'd0;
            rd_ptr_next = ~rd_ptr_reg;
        end
        else if (pop)
        begin
            sub_next = sub_reg + 2'd1;
        end
        count_next = count_reg + {1'b0, push} - {1'b0, head_done};
    end

    // Hold queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            sub_reg    <= 2'd0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            sub_reg    <= sub_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
        end
    end

    // Store a new result group
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_bundle;
        end
    end

endmodule

/* rtl/transparent_span_encoder.sv */
// Transparent span encoder. Takes one 8-bit pixel per beat in row order and
// packs runs of non-transparent pixels into spans of a word-addressed store:
// a header word (start x low half, length high half) followed by the pixels
// four to a word, the last word padded with 0xCD. Data words leave as they
// fill, the header when the span closes, and a row-table record (the byte
// offset reached) at every row end. Each pixel is processed in the cycle it
// is accepted, so pixels go in at one per clock while pixel_stall is low; a
// pixel causes zero to three result beats, delivered one per clock while
// result_stall is low from a two-group result queue, and pixel_stall rises
// only while that queue holds two groups. Write transparent_value only while
// the encoder is idle.
module transparent_span_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        transparent_write,
    input  logic [7:0]  transparent_value,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [7:0]  pixel,
    input  logic        row_last,
    input  logic        image_start,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [21:0] word_address,
    output logic [31:0] word,
    output logic        last,
    output logic        overflow
);
    import tse_pkg::*;

    tse_state_t  state_reg;
    tse_state_t  state_next;
    logic [7:0]  transparent_reg;
    tse_bundle_t bundle;
    logic        has_result;
    logic        accept;
    logic        queue_full;

    assign pixel_stall = queue_full;
    assign accept      = pixel_valid && !pixel_stall;

    // Hold the transparent key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transparent_reg <= 8'd0;
        end
        else if (transparent_write)
        begin
            transparent_reg <= transparent_value;
        end
    end

    // Advance encoder state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    tse_step u_step (
        .state             (state_reg),
        .transparent_value (transparent_reg),
        .pixel             (pixel),
        .row_last          (row_last),
        .image_start       (image_start),
        .state_next        (state_next),
        .bundle            (bundle),
        .has_result        (has_result)
    );

    tse_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept && has_result),
        .push_bundle  (bundle),
        .full         (queue_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .word_address (word_address),
        .word         (word),
        .last         (last),
        .overflow     (overflow)
    );

endmodule

/* tb/tb_transparent_span_encoder.sv */
`timescale 1ns / 1ps

module tb_transparent_span_encoder;

    import tse_pkg::*;

    // One expected result beat
    typedef struct packed {
        tse_kind_t            kind;
        logic [ADDR_BITS-1:0] addr;
        logic [31:0]          data;
        logic                 last;
        logic                 ovf;
    } span_beat_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic        clk;
    logic        rst_n;
    logic        transparent_write;
    logic [7:0]  transparent_value;
    logic        pixel_valid;
    logic        pixel_stall;
    logic [7:0]  pixel;
    logic        row_last;
    logic        image_start;
    logic        result_valid;
    logic        result_stall;
    logic [1:0]  kind;
    logic [21:0] word_address;
    logic [31:0] word;
    logic        last;
    logic        overflow;

    // Encoder image kept by the testbench
    logic [7:0]           model_transparent;
    logic [15:0]          col;
    logic [ROW_BITS-1:0]  rows_done;
    logic                 span_active;
    logic [15:0]          span_x;
    logic [15:0]          span_len;
    logic [ADDR_BITS-1:0] header_addr;
    logic [23:0]          pending_bytes;
    logic [1:0]           pending_count;
    logic [ADDR_BITS-1:0] write_addr;
    logic                 sticky_overflow;

    span_beat_t span_beats_due[$];
    span_beat_t step_beats[$];

    int unsigned mismatch_count;
    int unsigned beats_checked;
    int unsigned pixels_sent;
    int unsigned settings_used;
    int unsigned burst_left;

    transparent_span_encoder dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .transparent_write (transparent_write),
        .transparent_value (transparent_value),
        .pixel_valid       (pixel_valid),
        .pixel_stall       (pixel_stall),
        .pixel             (pixel),
        .row_last          (row_last),
        .image_start       (image_start),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .kind              (kind),
        .word_address      (word_address),
        .word              (word),
        .last              (last),
        .overflow          (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Hand out the next store word, flag a wrap of the address space
    task automatic claim_word(output logic [ADDR_BITS-1:0] addr);
        addr = write_addr;
        write_addr = write_addr + 1'b1;
        if (write_addr == '0)
            sticky_overflow = 1'b1;
    endtask

    // Append one beat to the list for the current pixel
    task automatic add_step_beat(input tse_kind_t k, input logic [ADDR_BITS-1:0] a,
                                 input logic [31:0] d);
        span_beat_t beat;
        beat = '{k, a, d, 1'b0, 1'b0};
        step_beats.insert(step_beats.size(), beat);
    endtask

    // Flush the partial word with padding, then emit the header
    task automatic close_model_span();
        logic [31:0]          padded;
        logic [ADDR_BITS-1:0] addr;
        if (pending_count != 2'd0)
        begin
            padded = {8'h00, pending_bytes};
            for (int b = 0; b < 4; b++)
            begin
                if (b >= pending_count)
                    padded[8*b +: 8] = PAD_BYTE;
            end
            claim_word(addr);
            add_step_beat(KIND_DATA, addr, padded);
        end
        add_step_beat(KIND_HEADER, header_addr, {span_len, span_x});
        span_active = 1'b0;
        pending_bytes = '0;
        pending_count = 2'd0;
    endtask

    // Work out the beats one accepted pixel causes and queue them
    task automatic encode_pixel(input logic [7:0] p, input logic rl, input logic is);
        logic                 opaque;
        logic [ADDR_BITS-1:0] addr;
        span_beat_t           beat;
        step_beats.delete();
        if (is)
        begin
            col = '0;
            rows_done = '0;
            span_active = 1'b0;
            span_len = '0;
            pending_bytes = '0;
            pending_count = 2'd0;
            write_addr = '0;
            sticky_overflow = 1'b0;
        end

        opaque = (p != model_transparent);
        if (col >= MAX_ROW_WIDTH)
        begin
            sticky_overflow = 1'b1;
            opaque = 1'b0;
        end

        if (opaque)
        begin
            if (!span_active)
            begin
                span_active = 1'b1;
                span_x = col;
                span_len = '0;
                claim_word(header_addr);
                pending_bytes = '0;
                pending_count = 2'd0;
            end
            if (pending_count == 2'd3)
            begin
                claim_word(addr);
                add_step_beat(KIND_DATA, addr, {p, pending_bytes});
                pending_bytes = '0;
                pending_count = 2'd0;
            end
            else
            begin
                pending_bytes[8*pending_count +: 8] = p;
                pending_count = pending_count + 1'b1;
            end
            span_len = span_len + 1'b1;
        end
        else if (span_active)
            close_model_span();

        if (rl)
        begin
            if (span_active)
                close_model_span();
            rows_done = rows_done + 1'b1;
            if (rows_done == '0)
                sticky_overflow = 1'b1;
            add_step_beat(KIND_ROW, rows_done, {8'h00, write_addr, 2'b00});
            col = '0;
        end
        else if (col < MAX_ROW_WIDTH)
            col = col + 1'b1;

        foreach (step_beats[i])
        begin
            beat = step_beats[i];
            beat.last = (i == step_beats.size() - 1);
            beat.ovf = sticky_overflow;
            span_beats_due.insert(span_beats_due.size(), beat);
        end
    endtask

    // Drive one pixel beat, hold it until accepted, then maybe open a gap
    task automatic send_pixel(input logic [7:0] p, input logic rl, input logic is);
        @(negedge clk);
        pixel_valid <= 1'b1;
        pixel <= p;
        row_last <= rl;
        image_start <= is;
        do
            @(posedge clk);
        while (pixel_stall);
        encode_pixel(p, rl, is);
        pixels_sent++;
        if (burst_left == 0)
        begin
            @(negedge clk);
            pixel_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
        end
        else
            burst_left--;
    endtask

    // Stop sending and wait for every expected beat, then let the clock run on
    task automatic drain_results();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (span_beats_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_transparent(input logic [7:0] v);
        @(negedge clk);
        transparent_write <= 1'b1;
        transparent_value <= v;
        @(negedge clk);
        transparent_write <= 1'b0;
        model_transparent = v;
        settings_used++;
    endtask

    // Full words, closes with and without padding, empty and one-pixel rows
    task automatic test_span_shapes();
        send_pixel(8'h00, 1'b0, 1'b1);
        send_pixel(8'hFF, 1'b0, 1'b0);
        send_pixel(8'h01, 1'b0, 1'b0);
        send_pixel(8'h80, 1'b0, 1'b0);
        send_pixel(8'h7F, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'hAA, 1'b0, 1'b0);
        send_pixel(8'h55, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b1, 1'b0);
        send_pixel(8'h00, 1'b1, 1'b0);
        send_pixel(8'hC3, 1'b1, 1'b0);
        send_pixel(8'h10, 1'b0, 1'b0);
        send_pixel(8'h20, 1'b0, 1'b0);
        send_pixel(8'h30, 1'b0, 1'b0);
        send_pixel(8'h40, 1'b0, 1'b0);
        send_pixel(8'h50, 1'b1, 1'b0);
    endtask

    // Image start while a span is open drops that span
    task automatic test_image_restart();
        send_pixel(8'h12, 1'b0, 1'b0);
        send_pixel(8'h34, 1'b0, 1'b0);
        send_pixel(8'h56, 1'b0, 1'b1);
        send_pixel(8'h9A, 1'b1, 1'b0);
        send_pixel(8'hFF, 1'b1, 1'b1);
        send_pixel(8'h00, 1'b1, 1'b1);
    endtask

    // Row running past the maximum width: forced close, sticky flag, clear
    task automatic test_wide_row();
        for (int i = 0; i < 4100; i++)
        begin
            send_pixel((i >= 4093) ? 8'hA0 + 8'(i % 16) : 8'h00, i == 4099, i == 0);
        end
        send_pixel(8'h11, 1'b0, 1'b0);
        send_pixel(8'h22, 1'b1, 1'b0);
        send_pixel(8'h33, 1'b1, 1'b1);
    endtask

    // Rows of alternating runs under one transparent setting, some noise
    task automatic test_random_rows(input logic [7:0] tv, input int unsigned count);
        int unsigned sent;
        int unsigned width;
        int unsigned run_left;
        logic        run_opaque;
        logic [7:0]  p;
        logic        is;
        logic        rl;
        logic        paused;
        drain_results();
        write_transparent(tv);
        sent = 0;
        paused = 1'b0;
        run_left = 0;
        run_opaque = 1'b0;
        while (sent < count)
        begin
            width = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48)
                                                 : $urandom_range(1, 12);
            for (int x = 0; x < width; x++)
            begin
                if (run_left == 0)
                begin
                    run_opaque = ($urandom_range(0, 2) != 0);
                    run_left = $urandom_range(1, 7);
                end
                run_left--;
                if (run_opaque)
                begin
                    do
                        p = 8'($urandom_range(0, 255));
                    while (p == model_transparent);
                end
                else
                    p = model_transparent;
                is = (x == 0) && ($urandom_range(0, 7) == 0);
                rl = (x == width - 1);
                // occasional broken beat: any value, stray row end or restart
                if ($urandom_range(0, 19) == 0)
                begin
                    p = 8'($urandom);
                    is = 1'($urandom_range(0, 1));
                    rl = 1'($urandom_range(0, 1));
                end
                send_pixel(p, rl, is);
                sent++;
                // hold the sender once until every result is out
                if (!paused && sent >= count / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end
    endtask

    // Receiver stall pattern, switching style at random intervals
    initial
    begin : stall_pattern
        stall_mode_t mode;
        int unsigned mode_left;
        int unsigned phase;
        result_stall = 1'b0;
        mode = STALL_NONE;
        mode_left = 0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            phase++;
            case (mode)
                STALL_NONE:     result_stall <= 1'b0;
                STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
                default:        result_stall <= ((phase % 5) < 2);
            endcase
        end
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge clk)
    begin : check_beat
        span_beat_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            beats_checked++;
            if (span_beats_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected beat kind=%0d addr=%0h word=%08h last=%0b ovf=%0b",
                             $time, kind, word_address, word, last, overflow);
            end
            else
            begin
                want = span_beats_due.pop_front();
                if (kind !== want.kind || word_address !== want.addr || word !== want.data ||
                    last !== want.last || overflow !== want.ovf)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $write("%0t: beat mismatch exp kind=%0d addr=%0h word=%08h ",
                               $time, want.kind, want.addr, want.data);
                        $write("last=%0b ovf=%0b got kind=%0d addr=%0h ",
                               want.last, want.ovf, kind, word_address);
                        $display("word=%08h last=%0b ovf=%0b", word, last, overflow);
                    end
                end
            end
        end
    end

    initial
    begin
        #10ms;
        $display("tb_transparent_span_encoder failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        transparent_write = 1'b0;
        transparent_value = 8'h00;
        pixel_valid = 1'b0;
        pixel = 8'h00;
        row_last = 1'b0;
        image_start = 1'b0;
        model_transparent = 8'h00;
        col = '0;
        rows_done = '0;
        span_active = 1'b0;
        span_x = '0;
        span_len = '0;
        header_addr = '0;
        pending_bytes = '0;
        pending_count = 2'd0;
        write_addr = '0;
        sticky_overflow = 1'b0;
        mismatch_count = 0;
        beats_checked = 0;
        pixels_sent = 0;
        settings_used = 0;
        burst_left = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_span_shapes();
        test_image_restart();
        test_wide_row();
        test_random_rows(8'h00, 65);
        test_random_rows(8'hFF, 65);
        test_random_rows(8'($urandom_range(1, 254)), 65);
        test_random_rows(PAD_BYTE, 65);
        drain_results();

        if (span_beats_due.size() != 0)
            mismatch_count += span_beats_due.size();

        $display("Sent %0d pixels and checked %0d result beats over %0d transparent settings,",
                 pixels_sent, beats_checked, settings_used);
        $display("with padded and unpadded spans, restarts mid-span and a row past max width.");
        if (mismatch_count == 0)
            $display("tb_transparent_span_encoder passed");
        else
            $display("tb_transparent_span_encoder failed");
        $finish;
    end

endmodule
